[hdl/sbi_pkg.sv]
// Package for the spatial bin insert unit: sizes, codes, controller states and
// the command/status structs between controller and datapath. No dependencies.
package sbi_pkg;

    localparam int AXIS_BINS  = 16;
    localparam int MAX_POINTS = 4096;
    localparam int COORD_BITS = 20;

    localparam int BIN_W      = $clog2(AXIS_BINS);
    localparam int ADDR_W     = 3 * BIN_W;
    localparam int NUM_BINS   = AXIS_BINS * AXIS_BINS * AXIS_BINS;
    localparam int HEAD_W     = $clog2(MAX_POINTS) + 1;
    localparam int ID_W       = 12;
    localparam int SIZE_W     = 16;
    localparam int CNT_W      = 5;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int LIMIT_W    = CNT_W + SIZE_W;
    localparam int WORK_W     = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;
    localparam int STEP_W     = (BIN_W > 1) ? $clog2(BIN_W) : 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int STATUS_W   = 2;

    localparam logic [SIZE_W-1:0] SMALL_SIZE   = SIZE_W'(26);
    localparam logic [SIZE_W-1:0] DEFAULT_SIZE = SIZE_W'(1280);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_Y     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_Z     = 3'd6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_WRITE,
        ST_CLEAR_SWEEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic setup;
        logic check;
        logic div_step;
        logic rd;
        logic wr;
        logic sweep_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic check_fail;
        logic step_last;
        logic axis_last;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage

[hdl/spatial_bin_insert_unit.sv]
// Top level of the spatial bin insert unit: controller plus datapath.
// Depends on sbi_pkg, sbi_ctrl and sbi_datapath.
//
// Usage:
//  Input channel (i_in_valid/o_in_ready): operation 0 inserts point_id at
//  (coord_x, coord_y, coord_z), operation 1 empties every bin.
//  Output channel (o_out_valid/i_out_ready): one result per input transfer,
//  in order: bin indices, former head of the bin (4096 = empty), status.
//  Config channel (i_cfg_valid/o_cfg_ready, always ready): write while idle.
//  An insert runs from input transfer to o_out_valid as follows:
//  per axis one setup, one range check and four quotient-bit steps of the
//  shared restoring divider, then a read and a write of the head memory
//  and the result load.
//  One item at a time; the next transfer can be taken in the cycle
//  after the result is loaded.
//  A point outside the grid is reported sooner, after its failing check.
//  A clear rewrites all 4096 head entries, one per cycle.
//  After reset the same sweep runs with o_in_ready low.
//  The result sits in an output register; the next item is taken while it
//  waits, but a second result holds in the controller until it is free.
module spatial_bin_insert_unit
    import sbi_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic [ID_W-1:0]              i_point_id,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [BIN_W-1:0]             o_bin_x,
    output logic [BIN_W-1:0]             o_bin_y,
    output logic [BIN_W-1:0]             o_bin_z,
    output logic [HEAD_W-1:0]            o_previous_head,
    output logic [STATUS_W-1:0]          o_status
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    sbi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    sbi_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_point_id      (i_point_id),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_operation     (i_operation),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_bin_x         (o_bin_x),
        .o_bin_y         (o_bin_y),
        .o_bin_z         (o_bin_z),
        .o_previous_head (o_previous_head),
        .o_status        (o_status)
    );

endmodule

[hdl/sbi_ctrl.sv]
// Controller for the spatial bin insert unit: sequences sweep, per-axis
// divide, head-table update and result hand-off. Depends on sbi_pkg.
module sbi_ctrl
    import sbi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_operation,
    input  t_stat i_stat,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_operation == OP_CLEAR) ? ST_CLEAR_SWEEP : ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_stat.check_fail ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.step_last) begin
                    n_state = i_stat.axis_last ? ST_READ : ST_SETUP;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state = ST_DONE;
            end
            ST_CLEAR_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |-> $past(o_cmd.rd))
        else $error("head write without preceding read");

    a_fail_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.check && i_stat.check_fail) |=> !o_cmd.div_step && !o_cmd.rd)
        else $error("dropped point entered divide or table access");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("input ready outside idle");

endmodule

[hdl/sbi_datapath.sv]
// Datapath for the spatial bin insert unit: configuration registers, shared
// restoring divider, bin head memory and result register. Depends on sbi_pkg.
module sbi_datapath
    import sbi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [ID_W-1:0]         i_point_id,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    input  logic                    i_operation,
    input  logic                    i_out_ready,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic                    o_out_valid,
    output logic [BIN_W-1:0]        o_bin_x,
    output logic [BIN_W-1:0]        o_bin_y,
    output logic [BIN_W-1:0]        o_bin_z,
    output logic [HEAD_W-1:0]       o_previous_head,
    output logic [STATUS_W-1:0]     o_status
);

    logic signed [COORD_BITS-1:0] r_min_x, r_min_y, r_min_z;
    logic [SIZE_W-1:0]            r_bin_size;
    logic [CNT_W-1:0]             r_bins_x, r_bins_y, r_bins_z;

    logic                         r_op;
    logic [ID_W-1:0]              r_id;
    logic [COORD_BITS-1:0]        r_coord [3];

    logic [1:0]                   r_axis;
    logic [STEP_W-1:0]            r_step;
    logic [DIFF_W-1:0]            r_rem;
    logic [LIMIT_W-1:0]           r_limit;
    logic [BIN_W-1:0]             r_bin [3];
    logic                         r_bad;

    logic [HEAD_W-1:0]            r_heads [NUM_BINS];
    logic [HEAD_W-1:0]            r_rd_data;
    logic [ADDR_W-1:0]            r_sweep;

    logic                         r_out_valid;
    logic [BIN_W-1:0]             r_out_bin [3];
    logic [HEAD_W-1:0]            r_out_head;
    logic [STATUS_W-1:0]          r_out_status;

    logic [SIZE_W-1:0]            eff_size;
    logic [CNT_W-1:0]             cnt_x, cnt_y, cnt_z, cnt_sel;
    logic [COORD_BITS-1:0]        coord_sel, min_sel;
    logic [DIFF_W-1:0]            diff;
    logic [WORK_W-1:0]            trial;
    logic                         ge;
    logic                         fail;
    logic [ADDR_W-1:0]            addr;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == '0) begin
            r = CNT_W'(1);
        end else if (n > CNT_W'(AXIS_BINS)) begin
            r = CNT_W'(AXIS_BINS);
        end
        return r;
    endfunction

    assign eff_size = (r_bin_size < SMALL_SIZE) ? DEFAULT_SIZE : r_bin_size;
    assign cnt_x    = clamp_cnt(r_bins_x);
    assign cnt_y    = clamp_cnt(r_bins_y);
    assign cnt_z    = clamp_cnt(r_bins_z);

    always_comb begin
        case (r_axis)
            AXIS_X: begin
                min_sel = r_min_x;
                cnt_sel = cnt_x;
            end
            AXIS_Y: begin
                min_sel = r_min_y;
                cnt_sel = cnt_y;
            end
            default: begin
                min_sel = r_min_z;
                cnt_sel = cnt_z;
            end
        endcase
    end

    assign coord_sel = r_coord[r_axis];
    assign diff  = {coord_sel[COORD_BITS-1], coord_sel} - {min_sel[COORD_BITS-1], min_sel};
    assign trial = WORK_W'(eff_size) << r_step;
    assign ge    = WORK_W'(r_rem) >= trial;
    assign fail  = r_rem[DIFF_W-1]
                   || (WORK_W'(r_rem) >= WORK_W'(r_limit))
                   || ({1'b0, r_id} >= (ID_W+1)'(MAX_POINTS));
    assign addr  = {r_bin[0], r_bin[1], r_bin[2]};

    assign o_stat.check_fail = fail;
    assign o_stat.step_last  = (r_step == '0);
    assign o_stat.axis_last  = (r_axis == AXIS_Z);
    assign o_stat.sweep_last = (r_sweep == '1);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x    <= '0;
            r_min_y    <= '0;
            r_min_z    <= '0;
            r_bin_size <= DEFAULT_SIZE;
            r_bins_x   <= CNT_W'(16);
            r_bins_y   <= CNT_W'(16);
            r_bins_z   <= CNT_W'(16);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_MIN_X: r_min_x    <= i_cfg_data[COORD_BITS-1:0];
                CFG_GRID_MIN_Y: r_min_y    <= i_cfg_data[COORD_BITS-1:0];
                CFG_GRID_MIN_Z: r_min_z    <= i_cfg_data[COORD_BITS-1:0];
                CFG_BIN_SIZE:   r_bin_size <= i_cfg_data[SIZE_W-1:0];
                CFG_BINS_X:     r_bins_x   <= i_cfg_data[CNT_W-1:0];
                CFG_BINS_Y:     r_bins_y   <= i_cfg_data[CNT_W-1:0];
                CFG_BINS_Z:     r_bins_z   <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_operation;
            r_id       <= i_point_id;
            r_coord[0] <= i_coord_x;
            r_coord[1] <= i_coord_y;
            r_coord[2] <= i_coord_z;
        end
    end

    // per-axis divide, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_X;
            r_step <= '0;
            r_bad  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_axis <= AXIS_X;
                r_bad  <= 1'b0;
            end
            if (i_cmd.setup) begin
                r_step <= STEP_W'(BIN_W - 1);
            end
            if (i_cmd.check) begin
                r_bad <= fail;
            end
            if (i_cmd.div_step) begin
                if (r_step == '0) begin
                    if (r_axis != AXIS_Z) begin
                        r_axis <= r_axis + 2'd1;
                    end
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_rem         <= diff;
            r_limit       <= LIMIT_W'(cnt_sel) * LIMIT_W'(eff_size);
            r_bin[r_axis] <= '0;
        end
        if (i_cmd.div_step) begin
            r_bin[r_axis] <= {r_bin[r_axis][BIN_W-2:0], ge};
            if (ge) begin
                r_rem <= r_rem - DIFF_W'(trial);
            end
        end
    end

    // bin heads; cleared by a full sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_wr) begin
            r_heads[r_sweep] <= HEAD_W'(MAX_POINTS);
        end else if (i_cmd.wr) begin
            r_heads[addr] <= HEAD_W'(r_id);
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_heads[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_wr) begin
            r_sweep <= r_sweep + ADDR_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_op == OP_CLEAR) begin
                r_out_bin[0] <= '0;
                r_out_bin[1] <= '0;
                r_out_bin[2] <= '0;
                r_out_head   <= '0;
                r_out_status <= STATUS_CLEARED;
            end else if (r_bad) begin
                r_out_bin[0] <= '0;
                r_out_bin[1] <= '0;
                r_out_bin[2] <= '0;
                r_out_head   <= '0;
                r_out_status <= STATUS_DROPPED;
            end else begin
                r_out_bin[0] <= r_bin[0];
                r_out_bin[1] <= r_bin[1];
                r_out_bin[2] <= r_bin[2];
                r_out_head   <= r_rd_data;
                r_out_status <= STATUS_INSERTED;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bin_x         = r_out_bin[0];
    assign o_bin_y         = r_out_bin[1];
    assign o_bin_z         = r_out_bin[2];
    assign o_previous_head = r_out_head;
    assign o_status        = r_out_status;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");

    a_bins_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (CNT_W'(r_bin[0]) < cnt_x) && (CNT_W'(r_bin[1]) < cnt_y)
                     && (CNT_W'(r_bin[2]) < cnt_z) && !r_bad)
        else $error("bin index beyond configured count at table access");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result load lost");

endmodule
